/* rtl/aic_pkg.sv */
// ----------------------------------------------------------------------------
// Accumulator calculator package
// Operation codes, status codes and sequencer states shared by the block.
// ----------------------------------------------------------------------------
package aic_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_REM = 3'd4,
    OP_POW = 3'd5,
    OP_RSV6 = 3'd6,
    OP_RSV7 = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_REM_ZERO = 2'd2,
    ST_RSV     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_POW_MUL,
    S_POW_SQ,
    S_DONE
  } state_t;

endpackage

/* rtl/aic_mul.sv */
// ----------------------------------------------------------------------------
// Shared multiplier
// Registered 32 by 32 multiply that keeps the low 32 bits of the product.
// ----------------------------------------------------------------------------
module aic_mul (
  input  logic        clk,
  input  logic [31:0] mul_a,
  input  logic [31:0] mul_b,
  output logic [31:0] mul_p
);
  import aic_pkg::*;

  logic [63:0] full;
  logic [31:0] prod_r;

  assign full  = {32'd0, mul_a} * {32'd0, mul_b};
  assign mul_p = prod_r;

  always_ff @(posedge clk) begin
    prod_r <= full[DataW-1:0];
  end
endmodule

/* rtl/accumulator_integer_calculator_unit.sv */
// ----------------------------------------------------------------------------
// Accumulator integer calculator
// Add, subtract, multiply, divide, remainder and power on a 32-bit accumulator.
// ----------------------------------------------------------------------------
// Add and subtract results go straight into the output register; multiply takes
// one pass through the registered multiplier first. Divide and remainder use a
// restoring divider, one quotient bit per cycle. Power runs square-and-multiply
// on one registered multiplier, two multiplier passes per exponent bit up to the
// highest set bit. One command is in flight at a time; the next beat
// is taken once the result beat has left the output register.
module accumulator_integer_calculator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic        in_use_accumulator,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_result,
  output logic [1:0]  out_status
);
  import aic_pkg::*;

  state_t      state_r, state_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] a_r, a_nxt;      // dividend magnitude / power base square
  logic [31:0] b_r, b_nxt;      // divisor magnitude / exponent
  logic [31:0] q_r, q_nxt;      // quotient / power product
  logic [32:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        neg_q_r, neg_q_nxt, neg_r_r, neg_r_nxt, is_rem_r, is_rem_nxt;
  logic        wait_r, wait_nxt;
  logic [31:0] res_r, res_nxt;
  status_t     st_r, st_nxt;
  logic [31:0] mul_a, mul_b, mul_p;
  logic [31:0] lhs;
  logic [32:0] trial;

  aic_mul u_mul (.clk(clk), .mul_a(mul_a), .mul_b(mul_b), .mul_p(mul_p));

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = (state_r == S_DONE);
  assign out_result = res_r;
  assign out_status = st_r;
  assign lhs   = in_use_accumulator ? acc_r : in_operand_a;
  assign trial = {rem_r[31:0], a_r[31]} - {1'b0, b_r};

  always_comb begin
    state_nxt = state_r; acc_nxt = acc_r; a_nxt = a_r; b_nxt = b_r; q_nxt = q_r;
    rem_nxt = rem_r; cnt_nxt = cnt_r; neg_q_nxt = neg_q_r; neg_r_nxt = neg_r_r;
    is_rem_nxt = is_rem_r; wait_nxt = 1'b0; res_nxt = res_r; st_nxt = st_r;
    mul_a = a_r; mul_b = q_r;
    unique case (state_r)
      S_IDLE: begin
        mul_a = lhs; mul_b = in_operand_b;
        if (in_valid) begin
          st_nxt = ST_OK;
          res_nxt = acc_r;
          state_nxt = S_DONE;
          case (op_t'(in_operation))
            OP_ADD: res_nxt = lhs + in_operand_b;
            OP_SUB: res_nxt = lhs - in_operand_b;
            OP_MUL: begin
              wait_nxt = 1'b1;
              state_nxt = S_POW_SQ;
              cnt_nxt = 6'd0;
              b_nxt = 32'd0;
            end
            OP_DIV, OP_REM: begin
              if (in_operand_b == 32'd0) begin
                st_nxt = (in_operation == OP_DIV) ? ST_DIV_ZERO : ST_REM_ZERO;
              end else begin
                a_nxt = lhs[31] ? -lhs : lhs;
                b_nxt = in_operand_b[31] ? -in_operand_b : in_operand_b;
                neg_q_nxt = lhs[31] ^ in_operand_b[31];
                neg_r_nxt = lhs[31];
                is_rem_nxt = (in_operation == OP_REM);
                rem_nxt = 33'd0; q_nxt = 32'd0; cnt_nxt = 6'd32;
                state_nxt = S_DIV;
              end
            end
            OP_POW: begin
              if (in_operand_b == 32'd0) res_nxt = 32'd1;
              else if (in_operand_b == 32'hFFFF_FFFF) res_nxt = lhs;
              else if (in_operand_b[31]) res_nxt = 32'd0;
              else begin
                a_nxt = lhs; b_nxt = in_operand_b; q_nxt = 32'd1;
                state_nxt = S_POW_MUL; wait_nxt = 1'b0;
              end
            end
            default: ;
          endcase
          acc_nxt = res_nxt;
        end
      end
      S_DIV: begin
        if (!trial[32]) begin
          rem_nxt = trial; q_nxt = {q_r[30:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[31:0], a_r[31]}; q_nxt = {q_r[30:0], 1'b0};
        end
        a_nxt = {a_r[30:0], 1'b0};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          if (is_rem_r) res_nxt = neg_r_r ? -rem_nxt[31:0] : rem_nxt[31:0];
          else res_nxt = neg_q_r ? -q_nxt : q_nxt;
          acc_nxt = res_nxt;
          state_nxt = S_DONE;
        end
      end
      S_POW_MUL: begin
        // Multiply product by the base when the low exponent bit is set.
        mul_a = q_r; mul_b = a_r;
        if (!wait_r) wait_nxt = 1'b1;
        else begin
          if (b_r[0]) q_nxt = mul_p;
          mul_a = a_r; mul_b = a_r;
          b_nxt = b_r >> 1;
          if ((b_r >> 1) == 32'd0) begin
            res_nxt = b_r[0] ? mul_p : q_r;
            acc_nxt = res_nxt;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_POW_SQ;
            wait_nxt = 1'b1;
          end
        end
      end
      S_POW_SQ: begin
        // Multiply result of the square (or the plain product) arrives here.
        if (b_r == 32'd0) begin
          res_nxt = mul_p; acc_nxt = mul_p; state_nxt = S_DONE;
        end else begin
          a_nxt = mul_p; state_nxt = S_POW_MUL;
          mul_a = q_r; mul_b = mul_p;
          wait_nxt = 1'b1;
        end
      end
      S_DONE: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      acc_r   <= 32'd0;
      wait_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      wait_r  <= wait_nxt;
    end
    a_r <= a_nxt; b_r <= b_nxt; q_r <= q_nxt; rem_r <= rem_nxt; cnt_r <= cnt_nxt;
    neg_q_r <= neg_q_nxt; neg_r_r <= neg_r_nxt; is_rem_r <= is_rem_nxt;
    res_r <= res_nxt; st_r <= st_nxt;
  end

  a_result_is_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result == acc_r)) else $error("result differs from accumulator");
  a_no_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("ready while result pending");
  a_err_keeps_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> $stable(acc_r))
    else $error("error changed accumulator");
endmodule

/* tb/accumulator_integer_calculator_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accumulator calculator testbench
// Drives a table of directed commands and then random commands through the
// valid/ready ports, predicts each result beat and compares it field by field.
// ----------------------------------------------------------------------------
module accumulator_integer_calculator_unit_tb;
  import aic_pkg::*;

  typedef struct packed {
    op_t         op;
    logic        use_acc;
    logic [31:0] a;
    logic [31:0] b;
    logic        known;
    logic [31:0] res;
    status_t     st;
  } cmd_row_t;

  typedef struct packed {
    logic [31:0] res;
    status_t     st;
  } calc_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_operation = '0;
  logic in_use_accumulator = 1'b0;
  logic signed [31:0] in_operand_a = '0;
  logic signed [31:0] in_operand_b = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_result;
  logic [1:0] out_status;

  logic [31:0] model_acc;
  calc_out_t pending_q[$];
  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int send_idle = 0;
  int recv_stall = 0;

  accumulator_integer_calculator_unit dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [31:0] magnitude(logic [31:0] v);
    return v[31] ? 32'(0 - v) : v;
  endfunction

  function automatic logic [31:0] int_power(logic [31:0] base, logic [31:0] e);
    logic [31:0] acc;
    logic [31:0] sq;
    acc = 32'd1;
    sq = base;
    if (e == 0) return 32'd1;
    if (e[31]) return (e == 32'hFFFF_FFFF) ? base : 32'd0;
    while (e != 0) begin
      if (e[0]) acc = acc * sq;
      sq = sq * sq;
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic calc_out_t compute_command(op_t op, logic use_acc,
                                                logic [31:0] opa, logic [31:0] b);
    calc_out_t o;
    logic [31:0] a;
    logic [31:0] q;
    a = use_acc ? model_acc : opa;
    o.res = model_acc;
    o.st = ST_OK;
    case (op)
      OP_ADD: o.res = a + b;
      OP_SUB: o.res = a - b;
      OP_MUL: o.res = a * b;
      OP_DIV: begin
        if (b == 0) o.st = ST_DIV_ZERO;
        else begin
          q = magnitude(a) / magnitude(b);
          o.res = (a[31] ^ b[31]) ? 32'(0 - q) : q;
        end
      end
      OP_REM: begin
        if (b == 0) o.st = ST_REM_ZERO;
        else begin
          q = magnitude(a) % magnitude(b);
          o.res = a[31] ? 32'(0 - q) : q;
        end
      end
      OP_POW: o.res = int_power(a, b);
      default: ;
    endcase
    model_acc = o.res;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch on result beat %0d: %s got %h, expected %h", beats_out, what,
             got, want);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        errors++;
        $display("unexpected result beat %0d", beats_out);
      end else begin
        calc_out_t e;
        e = pending_q.pop_front();
        if (out_result !== e.res) report_mismatch("result", out_result, e.res);
        if (out_status !== e.st) report_mismatch("status", 32'(out_status), 32'(e.st));
      end
      beats_out++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !($urandom_range(99) < recv_stall);
  end

  task automatic send_command(op_t op, logic use_acc, logic [31:0] a, logic [31:0] b,
                              logic known, logic [31:0] res, status_t st);
    calc_out_t o;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_use_accumulator <= use_acc;
    in_operand_a <= a;
    in_operand_b <= b;
    do @(posedge clk); while (!in_ready);
    o = compute_command(op, use_acc, a, b);
    if (known && (o.res !== res || o.st !== st)) begin
      errors++;
      $display("directed row %0d disagrees with prediction", beats_in);
    end
    pending_q.push_back(o);
    beats_in++;
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return 32'h8000_0000 + $urandom_range(2);
      1: return 32'h7FFF_FFFF - $urandom_range(2);
      2: return 32'($signed($urandom_range(8)) - 4);
      3: return 32'($signed($urandom_range(200)) - 100);
      default: return $urandom;
    endcase
  endfunction

  cmd_row_t directed[] = '{
    '{OP_ADD, 1'b1, 32'h0, 32'h0, 1'b1, 32'h0, ST_OK},
    '{OP_ADD, 1'b0, 32'h7FFF_FFFF, 32'h1, 1'b1, 32'h8000_0000, ST_OK},
    '{OP_SUB, 1'b1, 32'hFFFF_FFFF, 32'h1, 1'b1, 32'h7FFF_FFFF, ST_OK},
    '{OP_MUL, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h1, ST_OK},
    '{OP_DIV, 1'b0, 32'h5, 32'h0, 1'b1, 32'h1, ST_DIV_ZERO},
    '{OP_REM, 1'b1, 32'h5, 32'h0, 1'b1, 32'h1, ST_REM_ZERO},
    '{OP_DIV, 1'b0, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, ST_OK},
    '{OP_REM, 1'b0, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0, ST_OK},
    '{OP_DIV, 1'b0, 32'hFFFF_FFF9, 32'h2, 1'b1, 32'hFFFF_FFFD, ST_OK},
    '{OP_REM, 1'b0, 32'hFFFF_FFF9, 32'h2, 1'b1, 32'hFFFF_FFFF, ST_OK},
    '{OP_REM, 1'b0, 32'h7, 32'hFFFF_FFFE, 1'b1, 32'h1, ST_OK},
    '{OP_POW, 1'b0, 32'h7, 32'h0, 1'b1, 32'h1, ST_OK},
    '{OP_POW, 1'b0, 32'h7, 32'hFFFF_FFFF, 1'b1, 32'h7, ST_OK},
    '{OP_POW, 1'b0, 32'h7, 32'hFFFF_FFFE, 1'b1, 32'h0, ST_OK},
    '{OP_POW, 1'b0, 32'h7, 32'h8000_0000, 1'b1, 32'h0, ST_OK},
    '{OP_POW, 1'b0, 32'h2, 32'd31, 1'b1, 32'h8000_0000, ST_OK},
    '{OP_POW, 1'b0, 32'h3, 32'h7FFF_FFFF, 1'b0, 32'h0, ST_OK},
    '{OP_POW, 1'b1, 32'h0, 32'h2, 1'b0, 32'h0, ST_OK},
    '{OP_RSV6, 1'b0, 32'h1234, 32'h5678, 1'b0, 32'h0, ST_OK},
    '{OP_RSV7, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, ST_OK},
    '{OP_MUL, 1'b1, 32'h0, 32'h7FFF_FFFF, 1'b0, 32'h0, ST_OK},
    '{OP_DIV, 1'b1, 32'h0, 32'h8000_0000, 1'b0, 32'h0, ST_OK}
  };

  initial begin
    #2_000_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int idle_s[4] = '{0, 77, 0, 7};
    int stall_s[4] = '{0, 0, 77, 7};
    int waited;
    op_t op;
    model_acc = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i])
      send_command(directed[i].op, directed[i].use_acc, directed[i].a, directed[i].b,
                   directed[i].known, directed[i].res, directed[i].st);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = idle_s[ph];
      recv_stall = stall_s[ph];
      for (int n = 0; n < 350; n++) begin
        op = op_t'($urandom_range(99) < 4 ? $urandom_range(7, 6) : $urandom_range(5));
        send_command(op, 1'($urandom), rand_operand(),
                     (op == OP_POW && $urandom_range(3) != 0) ?
                       32'($urandom_range(40)) : rand_operand(),
                     1'b0, 32'h0, ST_OK);
      end
    end
    in_valid <= 1'b0;
    waited = 0;
    while (pending_q.size() != 0 && waited < 100_000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    $display("Sent %0d commands over four handshake phases, checked %0d result beats.",
             beats_in, beats_out);
    $display("Operations covered: all six, reserved codes, zero divisors, edge operands.");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/aic_pkg.sv
rtl/aic_mul.sv
rtl/accumulator_integer_calculator_unit.sv
tb/accumulator_integer_calculator_unit_tb.sv
